// ===== hw/rtl/ffpa_pkg.sv =====
`timescale 1ns / 1ps
package ffpa_pkg;
  localparam int MAX_PARTITIONS = 64;
  localparam int SIZE_BITS = 16;
  localparam int ID_BITS = 10;
  localparam logic [15:0] TOTAL_RESET = 16'd4096;

  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_NO_FIT = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_IDS_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_RELEASED = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT,      // reinitialize table
    CMD_LOAD,      // capture request
    CMD_SCAN,      // examine entry at scan pointer
    CMD_CLAIM,     // exact fit: mark entry owned
    CMD_SPLIT_SH,  // shift one entry up (from top toward pos)
    CMD_SPLIT_FIN, // write owned and remainder entries
    CMD_REL_MARK,  // free entry, add size to remaining
    CMD_MERGE_NX,  // merge with next entry, start shift down
    CMD_MERGE_PV,  // merge with previous entry, start shift down
    CMD_SHDN,      // shift one entry down
    CMD_RESULT     // present result
  } cmd_e_t;

  // Table read address for the registered read, relative to pointer or position
  typedef enum logic [2:0] {
    RD_PTR,
    RD_PTR_P1,
    RD_PTR_M1,
    RD_PTR_M2,
    RD_PTR_P2,
    RD_POS_P1,
    RD_POS_P2,
    RD_POS_M1
  } rd_sel_t;

  typedef struct packed {
    cmd_e_t cmd;
    rd_sel_t rd;
    logic [2:0] status;
    logic with_id;
  } ffpa_cmd_t;

  typedef struct packed {
    logic scan_end;    // scan pointer reached partition count
    logic hit;         // current entry matches
    logic exact;       // matching entry size equals request
    logic full;        // table has no spare entry
    logic ids_out;     // no id left
    logic op;          // captured op
    logic sh_done;     // shift sweep finished
    logic nx_free;     // next entry exists and is free
    logic pv_free;     // previous entry exists and is free
  } ffpa_stat_t;
endpackage

// ===== hw/rtl/first_fit_partition_allocator.sv =====
`timescale 1ns / 1ps
// A request scans the table entry by entry, then shifts table entries one by one
//   on a split or merge.
// Throughput: one request at a time; the next is taken after the result transfer.
// Reset: synchronous rst gives one free partition of 4096, next id zero.
// A total_memory write while idle reinitializes the table and keeps the id counter; during a request it is ignored.
module first_fit_partition_allocator #(
  parameter int MAX_PARTITIONS = ffpa_pkg::MAX_PARTITIONS,
  parameter int SIZE_BITS = ffpa_pkg::SIZE_BITS,
  parameter int ID_BITS = ffpa_pkg::ID_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  logic op,
  input  logic [15:0] request_size,
  input  logic [9:0] release_id,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] status,
  output logic [9:0] assigned_id,
  output logic [5:0] partition_index,
  output logic [15:0] fragmentation,
  output logic [15:0] remaining
);
  ffpa_pkg::ffpa_cmd_t cmd;
  ffpa_pkg::ffpa_stat_t stat;

  // Sequencer: scan, split and merge steps, result hold until transfer.
  ffpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  // Partition table and counters.
  ffpa_datapath #(
    .MAX_PARTITIONS(MAX_PARTITIONS), .SIZE_BITS(SIZE_BITS), .ID_BITS(ID_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .total_in(cfg_wdata), .op(op), .request_size(request_size),
    .release_id(release_id), .status(status), .assigned_id(assigned_id),
    .partition_index(partition_index), .fragmentation(fragmentation),
    .remaining(remaining)
  );
endmodule

// ===== hw/rtl/ffpa_datapath.sv =====
`timescale 1ns / 1ps
module ffpa_datapath #(
  parameter int MAX_PARTITIONS = ffpa_pkg::MAX_PARTITIONS,
  parameter int SIZE_BITS = ffpa_pkg::SIZE_BITS,
  parameter int ID_BITS = ffpa_pkg::ID_BITS
) (
  input  logic clk,
  input  logic rst,
  input  ffpa_pkg::ffpa_cmd_t cmd,
  output ffpa_pkg::ffpa_stat_t stat,
  input  logic [15:0] total_in,
  input  logic op,
  input  logic [15:0] request_size,
  input  logic [9:0] release_id,
  output logic [2:0] status,
  output logic [9:0] assigned_id,
  output logic [5:0] partition_index,
  output logic [15:0] fragmentation,
  output logic [15:0] remaining
);
  localparam int IW = $clog2(MAX_PARTITIONS);
  localparam int CW = $clog2(MAX_PARTITIONS + 1);

  logic [SIZE_BITS-1:0] size_mem [MAX_PARTITIONS];
  logic [ID_BITS-1:0] owner_mem [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] free_bits;

  logic [CW-1:0] count;
  logic [ID_BITS:0] next_id;
  logic [SIZE_BITS-1:0] rem;
  logic [SIZE_BITS-1:0] frag;
  logic [SIZE_BITS-1:0] req;
  logic [ID_BITS-1:0] rid;
  logic [ID_BITS-1:0] cur_id;
  logic op_q;
  logic [CW-1:0] ptr;
  logic [IW-1:0] pos;
  logic [SIZE_BITS-1:0] cur_size;

  logic [IW-1:0] p_i;
  logic [IW-1:0] rd_addr;
  logic [SIZE_BITS-1:0] rd_size;
  logic [ID_BITS-1:0] rd_owner;
  logic ent_free;
  logic [SIZE_BITS-1:0] ent_size;
  logic [ID_BITS-1:0] ent_owner;

  assign p_i = ptr[IW-1:0];
  assign ent_free = free_bits[p_i];
  assign ent_size = rd_size;
  assign ent_owner = rd_owner;

  // Address fetched this cycle, used by the next command
  always_comb begin
    unique case (cmd.rd)
      ffpa_pkg::RD_PTR:    rd_addr = p_i;
      ffpa_pkg::RD_PTR_P1: rd_addr = p_i + IW'(1);
      ffpa_pkg::RD_PTR_M1: rd_addr = p_i - IW'(1);
      ffpa_pkg::RD_PTR_M2: rd_addr = p_i - IW'(2);
      ffpa_pkg::RD_PTR_P2: rd_addr = p_i + IW'(2);
      ffpa_pkg::RD_POS_P1: rd_addr = pos + IW'(1);
      ffpa_pkg::RD_POS_P2: rd_addr = pos + IW'(2);
      ffpa_pkg::RD_POS_M1: rd_addr = pos - IW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    rd_size <= size_mem[rd_addr];
    rd_owner <= owner_mem[rd_addr];
  end

  always_comb begin
    stat.scan_end = (ptr >= count);
    stat.hit = (op_q == ffpa_pkg::OP_ALLOC) ? (ent_free && ent_size >= req)
                                            : (!ent_free && ent_owner == rid);
    stat.exact = (cur_size == req);
    stat.full = (count >= CW'(MAX_PARTITIONS));
    stat.ids_out = next_id[ID_BITS];
    stat.op = op_q;
    stat.sh_done = (ptr <= CW'(pos));
    stat.nx_free = (CW'(pos) + CW'(1) < count) && free_bits[pos + IW'(1)];
    stat.pv_free = (pos != '0) && free_bits[pos - IW'(1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(1);
      next_id <= '0;
      rem <= SIZE_BITS'(ffpa_pkg::TOTAL_RESET);
      free_bits <= MAX_PARTITIONS'(1);
      size_mem[0] <= SIZE_BITS'(ffpa_pkg::TOTAL_RESET);
      status <= '0;
    end else begin
      unique case (cmd.cmd)
        ffpa_pkg::CMD_INIT: begin
          count <= CW'(1);
          rem <= SIZE_BITS'(total_in);
          free_bits <= MAX_PARTITIONS'(1);
          size_mem[0] <= SIZE_BITS'(total_in);
        end
        ffpa_pkg::CMD_LOAD: begin
          op_q <= op;
          req <= SIZE_BITS'(request_size);
          rid <= ID_BITS'(release_id);
          cur_id <= next_id[ID_BITS-1:0];
          ptr <= '0;
          frag <= '0;
        end
        ffpa_pkg::CMD_SCAN: begin
          if (!stat.scan_end && stat.hit) begin
            // park the pointer at the top for a possible split
            pos <= p_i;
            cur_size <= ent_size;
            ptr <= count;
          end else begin
            if (!stat.scan_end && ent_free) frag <= frag + ent_size;
            ptr <= ptr + CW'(1);
          end
        end
        ffpa_pkg::CMD_CLAIM: begin
          free_bits[pos] <= 1'b0;
          owner_mem[pos] <= cur_id;
          rem <= rem - req;
        end
        ffpa_pkg::CMD_SPLIT_SH: begin
          // copy entry ptr-1 up to ptr, pointer starts at count
          size_mem[p_i] <= rd_size;
          owner_mem[p_i] <= rd_owner;
          free_bits[p_i] <= free_bits[p_i - IW'(1)];
          ptr <= ptr - CW'(1);
        end
        ffpa_pkg::CMD_SPLIT_FIN: begin
          size_mem[pos + IW'(1)] <= cur_size - req;
          free_bits[pos + IW'(1)] <= 1'b1;
          size_mem[pos] <= req;
          free_bits[pos] <= 1'b0;
          owner_mem[pos] <= cur_id;
          count <= count + CW'(1);
          rem <= rem - req;
        end
        ffpa_pkg::CMD_REL_MARK: begin
          rem <= rem + cur_size;
          free_bits[pos] <= 1'b1;
          ptr <= CW'(pos) + CW'(1);
        end
        ffpa_pkg::CMD_MERGE_NX: begin
          cur_size <= cur_size + rd_size;
          size_mem[pos] <= cur_size + rd_size;
          ptr <= CW'(pos) + CW'(1);
          count <= count - CW'(1);
        end
        ffpa_pkg::CMD_MERGE_PV: begin
          size_mem[pos - IW'(1)] <= rd_size + cur_size;
          ptr <= CW'(pos);
          count <= count - CW'(1);
        end
        ffpa_pkg::CMD_SHDN: begin
          // entry ptr takes ptr+1; runs while ptr < count (count already reduced)
          if (ptr < count) begin
            size_mem[p_i] <= rd_size;
            owner_mem[p_i] <= rd_owner;
            free_bits[p_i] <= free_bits[p_i + IW'(1)];
          end
          ptr <= ptr + CW'(1);
        end
        ffpa_pkg::CMD_RESULT: begin
          status <= cmd.status;
          assigned_id <= cmd.with_id ? 10'(cur_id) : '0;
          partition_index <= (cmd.status == ffpa_pkg::ST_ALLOCATED ||
                              cmd.status == ffpa_pkg::ST_RELEASED) ? 6'(pos) : '0;
          fragmentation <= (cmd.status == ffpa_pkg::ST_NO_FIT) ? 16'(frag) : '0;
          remaining <= 16'(rem);
          if (cmd.with_id) next_id <= next_id + (ID_BITS+1)'(1);
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// ===== hw/rtl/ffpa_ctrl.sv =====
`timescale 1ns / 1ps
module ffpa_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  ffpa_pkg::ffpa_stat_t stat,
  output ffpa_pkg::ffpa_cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN, S_FIT, S_SPLIT, S_REL, S_NX, S_SHN, S_PV, S_SHP,
    S_RES, S_OUT
  } state_t;

  state_t state;
  logic [2:0] st_q;
  logic wid_q;

  assign in_ready = (state == S_IDLE) && !cfg_we;

  always_comb begin
    cmd.cmd = ffpa_pkg::CMD_NONE;
    cmd.rd = ffpa_pkg::RD_PTR;
    cmd.status = st_q;
    cmd.with_id = wid_q;
    unique case (state)
      S_IDLE: begin
        if (cfg_we) cmd.cmd = ffpa_pkg::CMD_INIT;
        else if (in_valid) cmd.cmd = ffpa_pkg::CMD_LOAD;
      end
      S_SCAN: begin
        cmd.cmd = ffpa_pkg::CMD_SCAN;
        cmd.rd = ffpa_pkg::RD_PTR_P1;
      end
      S_FIT: begin
        if (stat.exact) cmd.cmd = ffpa_pkg::CMD_CLAIM;
        cmd.rd = ffpa_pkg::RD_PTR_M1;
      end
      S_SPLIT: begin
        cmd.cmd = stat.sh_done ? ffpa_pkg::CMD_SPLIT_FIN : ffpa_pkg::CMD_SPLIT_SH;
        cmd.rd = ffpa_pkg::RD_PTR_M2;
      end
      S_REL: begin
        cmd.cmd = ffpa_pkg::CMD_REL_MARK;
        cmd.rd = ffpa_pkg::RD_POS_P1;
      end
      S_NX: begin
        cmd.cmd = stat.nx_free ? ffpa_pkg::CMD_MERGE_NX : ffpa_pkg::CMD_NONE;
        cmd.rd = stat.nx_free ? ffpa_pkg::RD_POS_P2 : ffpa_pkg::RD_POS_M1;
      end
      S_SHN: begin
        cmd.cmd = ffpa_pkg::CMD_SHDN;
        cmd.rd = stat.scan_end ? ffpa_pkg::RD_POS_M1 : ffpa_pkg::RD_PTR_P2;
      end
      S_PV: begin
        cmd.cmd = stat.pv_free ? ffpa_pkg::CMD_MERGE_PV : ffpa_pkg::CMD_NONE;
        cmd.rd = ffpa_pkg::RD_POS_P1;
      end
      S_SHP: begin
        cmd.cmd = ffpa_pkg::CMD_SHDN;
        cmd.rd = ffpa_pkg::RD_PTR_P2;
      end
      S_RES: cmd.cmd = ffpa_pkg::CMD_RESULT;
      default: cmd.cmd = ffpa_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      st_q <= ffpa_pkg::ST_ALLOCATED;
      wid_q <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (!cfg_we && in_valid) state <= S_CHECK;
        S_CHECK: begin
          if (stat.op == ffpa_pkg::OP_ALLOC && stat.ids_out) begin
            st_q <= ffpa_pkg::ST_IDS_EXHAUSTED;
            wid_q <= 1'b0;
            state <= S_RES;
          end else begin
            wid_q <= (stat.op == ffpa_pkg::OP_ALLOC);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.scan_end) begin
            st_q <= (stat.op == ffpa_pkg::OP_ALLOC) ? ffpa_pkg::ST_NO_FIT
                                                    : ffpa_pkg::ST_NOT_FOUND;
            state <= S_RES;
          end else if (stat.hit) begin
            state <= (stat.op == ffpa_pkg::OP_ALLOC) ? S_FIT : S_REL;
          end
        end
        S_FIT: begin
          if (stat.exact) begin
            st_q <= ffpa_pkg::ST_ALLOCATED;
            state <= S_RES;
          end else if (stat.full) begin
            st_q <= ffpa_pkg::ST_TABLE_FULL;
            state <= S_RES;
          end else begin
            state <= S_SPLIT;
          end
        end
        S_SPLIT: if (stat.sh_done) begin
          st_q <= ffpa_pkg::ST_ALLOCATED;
          state <= S_RES;
        end
        S_REL: begin
          st_q <= ffpa_pkg::ST_RELEASED;
          state <= S_NX;
        end
        S_NX: state <= stat.nx_free ? S_SHN : S_PV;
        S_SHN: if (stat.scan_end) state <= S_PV;
        S_PV: state <= stat.pv_free ? S_SHP : S_RES;
        S_SHP: if (stat.scan_end) state <= S_RES;
        S_RES: begin
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  typedef struct packed {
    logic       op;
    logic [15:0] size;
    logic [9:0]  rid;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  aid;
    logic [5:0]  pidx;
    logic [15:0] frag;
    logic [15:0] remaining;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [15:0] request_size = '0;
  logic [9:0] release_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [9:0] assigned_id;
  logic [5:0] partition_index;
  logic [15:0] fragmentation;
  logic [15:0] remaining;

  first_fit_partition_allocator uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .request_size(request_size), .release_id(release_id),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .assigned_id(assigned_id), .partition_index(partition_index),
    .fragmentation(fragmentation), .remaining(remaining)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the partition table.
  logic [9:0]  tbl_owner [ffpa_pkg::MAX_PARTITIONS];
  logic        tbl_free [ffpa_pkg::MAX_PARTITIONS];
  logic [15:0] tbl_size [ffpa_pkg::MAX_PARTITIONS];
  int          tbl_count;
  int          id_next;
  logic [15:0] mem_left;
  logic [9:0]  last_ids[$];   // ids handed out, for realistic releases

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int    errors = 0;
  bit    idle_free = 1'b0;  // stretch with no idling
  bit    sink_hold = 1'b0;

  function automatic void table_init(logic [15:0] total);
    for (int i = 0; i < ffpa_pkg::MAX_PARTITIONS; i++) begin
      tbl_owner[i] = '0; tbl_free[i] = 1'b0; tbl_size[i] = '0;
    end
    tbl_free[0] = 1'b1;
    tbl_size[0] = total;
    tbl_count = 1;
    mem_left = total;
  endfunction

  function automatic void drop_slot(int k);
    for (int i = k; i + 1 < tbl_count; i++) begin
      tbl_owner[i] = tbl_owner[i+1]; tbl_free[i] = tbl_free[i+1];
      tbl_size[i] = tbl_size[i+1];
    end
    tbl_count--;
  endfunction

  // Compute the response for one request and update the shadow table.
  function automatic resp_t allocate_or_release(req_t r);
    resp_t e;
    int pos;
    logic [9:0] id;
    logic [15:0] fsum;
    e = '0;
    pos = -1;
    fsum = '0;
    if (r.op == ffpa_pkg::OP_ALLOC) begin
      if (id_next >= (1 << ffpa_pkg::ID_BITS)) begin
        e.status = ffpa_pkg::ST_IDS_EXHAUSTED;
      end else begin
        id = id_next[9:0];
        e.aid = id;
        id_next++;
        for (int i = 0; i < tbl_count; i++)
          if (pos < 0 && tbl_free[i] && tbl_size[i] >= r.size) pos = i;
        if (pos < 0) begin
          e.status = ffpa_pkg::ST_NO_FIT;
          for (int i = 0; i < tbl_count; i++)
            if (tbl_free[i]) fsum += tbl_size[i];
          e.frag = fsum;
        end else if (tbl_size[pos] == r.size) begin
          tbl_free[pos] = 1'b0; tbl_owner[pos] = id;
          mem_left -= r.size;
          e.status = ffpa_pkg::ST_ALLOCATED; e.pidx = pos[5:0];
          last_ids.push_back(id);
        end else if (tbl_count >= ffpa_pkg::MAX_PARTITIONS) begin
          e.status = ffpa_pkg::ST_TABLE_FULL;
        end else begin
          for (int i = tbl_count; i > pos; i--) begin
            tbl_owner[i] = tbl_owner[i-1]; tbl_free[i] = tbl_free[i-1];
            tbl_size[i] = tbl_size[i-1];
          end
          tbl_size[pos+1] = tbl_size[pos+1] - r.size;
          tbl_free[pos+1] = 1'b1;
          tbl_size[pos] = r.size; tbl_free[pos] = 1'b0; tbl_owner[pos] = id;
          tbl_count++;
          mem_left -= r.size;
          e.status = ffpa_pkg::ST_ALLOCATED; e.pidx = pos[5:0];
          last_ids.push_back(id);
        end
      end
    end else begin
      for (int i = 0; i < tbl_count; i++)
        if (pos < 0 && !tbl_free[i] && tbl_owner[i] == r.rid) pos = i;
      if (pos < 0) begin
        e.status = ffpa_pkg::ST_NOT_FOUND;
      end else begin
        e.status = ffpa_pkg::ST_RELEASED; e.pidx = pos[5:0];
        mem_left += tbl_size[pos];
        tbl_free[pos] = 1'b1; tbl_owner[pos] = '0;
        if (pos + 1 < tbl_count && tbl_free[pos+1]) begin
          tbl_size[pos] += tbl_size[pos+1];
          drop_slot(pos + 1);
        end
        if (pos != 0 && tbl_free[pos-1]) begin
          tbl_size[pos-1] += tbl_size[pos];
          drop_slot(pos);
        end
      end
    end
    e.remaining = mem_left;
    return e;
  endfunction

  function automatic req_t make_alloc(logic [15:0] sz);
    req_t r;
    r.op = ffpa_pkg::OP_ALLOC; r.size = sz; r.rid = 10'($urandom);
    return r;
  endfunction

  function automatic req_t make_release(logic [9:0] id);
    req_t r;
    r.op = ffpa_pkg::OP_RELEASE; r.size = 16'($urandom); r.rid = id;
    return r;
  endfunction

  // Random request sized for the current memory; mostly small so the table fills.
  function automatic req_t random_req(logic [15:0] total);
    int k;
    k = $urandom_range(0, 99);
    if (k < 8) return make_release(10'($urandom));
    if (k < 45 && last_ids.size() > 0)
      return make_release(last_ids[$urandom_range(0, last_ids.size() - 1)]);
    if (k < 50) return make_alloc(16'($urandom));
    if (k < 55) return make_alloc(16'd0);
    return make_alloc(16'($urandom_range(1, (total >> 5) + 2)));
  endfunction

  // Driver: hold the transfer until accepted, then advance.
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 &&
            (idle_free || $urandom_range(0, 99) >= 11)) begin
          req_t r;
          r = pending_reqs.pop_front();
          expected_resps.push_back(allocate_or_release(r));
          in_valid <= 1'b1;
          op <= r.op; request_size <= r.size; release_id <= r.rid;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        resp_t got, exp_r;
        got = '{status, assigned_id, partition_index, fragmentation, remaining};
        if (expected_resps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_resps.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10) $display("mismatch exp %p got %p", exp_r, got);
          end
        end
      end
      out_ready <= !sink_hold && (idle_free || $urandom_range(0, 99) >= 11);
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_total(logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    table_init(v);
    last_ids.delete();
  endtask

  // Let the queued requests go through so id_next reflects them.
  task automatic id_next_wait();
    while (pending_reqs.size() > 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] totals[5];
    totals = '{16'd0, 16'hFFFF, 16'd100, 16'd4096, 16'd37};
    id_next = 0;
    table_init(ffpa_pkg::TOTAL_RESET);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, exact fits, zero sizes, unknown ids, merges.
    pending_reqs.push_back(make_alloc(16'hFFFF));
    pending_reqs.push_back(make_alloc(16'd0));
    pending_reqs.push_back(make_alloc(16'd100));
    pending_reqs.push_back(make_alloc(16'd200));
    pending_reqs.push_back(make_alloc(16'd300));
    pending_reqs.push_back(make_release(10'd3));
    pending_reqs.push_back(make_release(10'd2));
    pending_reqs.push_back(make_release(10'd4));
    pending_reqs.push_back(make_release(10'd4));
    pending_reqs.push_back(make_release(10'h3FF));
    pending_reqs.push_back(make_alloc(16'd4096 - 16'd0));
    pending_reqs.push_back(make_release(10'd5));
    pending_reqs.push_back(make_alloc(16'd4096));
    pending_reqs.push_back(make_alloc(16'd1));
    drain();

    // Fill the table with tiny splits to hit table full and exact fit in a full table.
    write_total(16'd200);
    for (int i = 0; i < 70; i++) pending_reqs.push_back(make_alloc(16'd1));
    // the remainder is 200-63=137 in the last slot: exact fit still claimed
    pending_reqs.push_back(make_alloc(16'd137));
    pending_reqs.push_back(make_alloc(16'd1));
    drain();

    // Random runs per total: long receiver stall while sending, a no-idle stretch.
    foreach (totals[t]) begin
      write_total(totals[t]);
      if (t == 1) begin
        sink_hold = 1'b1;
        fork
          begin repeat (400) @(posedge clk); sink_hold = 1'b0; end
        join_none
      end
      if (t == 2) idle_free = 1'b1;
      if (t == 3) idle_free = 1'b0;
      for (int i = 0; i < 250; i++) begin
        pending_reqs.push_back(random_req(totals[t] == 0 ? 16'd64 : totals[t]));
        if (i == 120) begin
          // sender pause until everything has arrived
          while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
            @(posedge clk);
        end
      end
      drain();
    end

    // Use up the id space.
    write_total(16'hFFFF);
    while (id_next < (1 << ffpa_pkg::ID_BITS)) begin
      pending_reqs.push_back(make_alloc(16'($urandom_range(0, 3))));
      id_next_wait();
    end
    repeat (3) pending_reqs.push_back(make_alloc(16'($urandom_range(0, 3))));
    pending_reqs.push_back(make_release(last_ids.size() ? last_ids[0] : 10'd0));
    pending_reqs.push_back(make_alloc(16'd0));
    drain();

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb NOT OK");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/ffpa_pkg.sv
hw/rtl/ffpa_datapath.sv
hw/rtl/ffpa_ctrl.sv
hw/rtl/first_fit_partition_allocator.sv
dv/tb.sv
